// ===== sv/ymr_pkg.sv =====
package ymr_pkg;

    localparam logic [7:0] SYM_SOH = 8'h01;
    localparam logic [7:0] SYM_STX = 8'h02;
    localparam logic [7:0] SYM_ACK = 8'h06;
    localparam logic [7:0] SYM_NAK = 8'h15;
    localparam logic [7:0] SYM_EOT = 8'h04;
    localparam logic [7:0] SYM_C   = 8'h43;
    localparam logic [7:0] SYM_CAN = 8'h18;

    localparam int SHORT_SIZE = 128;
    localparam int LONG_SIZE  = 1024;

    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] RETRY_DEFAULT = 16'd10;

    typedef enum logic [1:0] {
        IN_BYTE  = 2'd0,
        IN_TICK  = 2'd1,
        IN_START = 2'd2,
        IN_NONE  = 2'd3
    } in_kind_t;

    typedef enum logic [2:0] {
        OK_PAYLOAD = 3'd0,
        OK_TX      = 3'd1,
        OK_ACCEPT  = 3'd2,
        OK_DROP    = 3'd3,
        OK_FILE    = 3'd4,
        OK_END     = 3'd5
    } out_kind_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_CANCEL  = 2'd1,
        ST_ERROR   = 2'd2,
        ST_TIMEOUT = 2'd3
    } end_status_t;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [7:0]  out_byte;
        logic [9:0]  payload_index;
        logic [10:0] deliver_count;
        logic [31:0] file_length;
        logic [1:0]  end_status;
    } res_t;

    // up to three results caused by one input transaction
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r2;
        res_t       r1;
        res_t       r0;
    } bundle_t;

    function automatic res_t mk_res(out_kind_t k, logic [7:0] b, logic [9:0] idx,
                                    logic [10:0] cnt, logic [31:0] flen,
                                    end_status_t st);
        res_t r;
        r.out_kind      = k;
        r.out_byte      = b;
        r.payload_index = idx;
        r.deliver_count = cnt;
        r.file_length   = flen;
        r.end_status    = st;
        return r;
    endfunction

    function automatic res_t tx_res(logic [7:0] b);
        return mk_res(OK_TX, b, 10'd0, 11'd0, 32'd0, ST_DONE);
    endfunction

    function automatic res_t end_res(end_status_t st);
        return mk_res(OK_END, 8'd0, 10'd0, 11'd0, 32'd0, st);
    endfunction

    // crc-16/xmodem, one byte msb first
    function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'd0};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== sv/ymr_if.sv =====
interface ymr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] rx_byte;
    modport source (output valid, kind, rx_byte, input ready);
    modport sink (input valid, kind, rx_byte, output ready);
endinterface

interface ymr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  out_kind;
    logic [7:0]  out_byte;
    logic [9:0]  payload_index;
    logic [10:0] deliver_count;
    logic [31:0] file_length;
    logic [1:0]  end_status;
    logic        last;
    modport source (output valid, out_kind, out_byte, payload_index, deliver_count,
                    file_length, end_status, last, input ready);
    modport sink (input valid, out_kind, out_byte, payload_index, deliver_count,
                  file_length, end_status, last, output ready);
endinterface

interface ymr_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] retry_limit;
    modport source (output valid, retry_limit, input ready);
    modport sink (input valid, retry_limit, output ready);
endinterface

// ===== sv/ymr_front.sv =====
module ymr_front
    import ymr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ymr_in_if.sink        in_ch,
    ymr_cfg_if.sink       cfg_ch,
    input  logic          q_full,
    output logic          push,
    output bundle_t       push_data
);

    typedef enum logic [1:0] { SP_IDLE, SP_META, SP_DATA } sess_t;
    typedef enum logic [1:0] { FP_HEAD, FP_DATA, FP_TAIL, FP_SPARE } fph_t;
    typedef enum logic [2:0] { V_NONE, V_GOOD, V_EOT, V_CAN, V_CRC, V_BAD } verdict_t;

    sess_t       sess_reg, sess_next;
    fph_t        fph_reg, fph_next;
    logic [10:0] bc_reg, bc_next;
    logic        lb_reg, lb_next;
    logic [7:0]  seq_reg, seq_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crch_reg, crch_next;
    logic        fbz_reg, fbz_next;
    logic        nf_reg, nf_next;
    logic        dop_reg, dop_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] dlv_reg, dlv_next;
    logic [15:0] idle_reg, idle_next;
    logic [15:0] limit_reg;

    logic        acc;
    logic        active;
    logic [10:0] size;
    logic [10:0] bc_inc;
    logic [7:0]  b;
    logic [35:0] len_t;
    logic [31:0] rem;
    logic [10:0] cnt;
    verdict_t    v;
    bundle_t     bd;

    assign in_ch.ready  = !q_full;
    assign cfg_ch.ready = 1'b1;
    assign acc    = in_ch.valid && !q_full;
    assign active = (sess_reg == SP_META) || (sess_reg == SP_DATA);
    assign size   = lb_reg ? 11'(LONG_SIZE) : 11'(SHORT_SIZE);
    assign bc_inc = bc_reg + 11'd1;
    assign b      = in_ch.rx_byte;
    assign len_t  = {1'b0, len_reg, 3'b0} + {3'b0, len_reg, 1'b0} + {28'd0, b - 8'h30};
    assign rem    = (len_reg > dlv_reg) ? (len_reg - dlv_reg) : 32'd0;
    assign cnt    = (rem < {21'd0, size}) ? rem[10:0] : size;

    always_comb
    begin
        sess_next = sess_reg;
        fph_next  = fph_reg;
        bc_next   = bc_reg;
        lb_next   = lb_reg;
        seq_next  = seq_reg;
        crc_next  = crc_reg;
        crch_next = crch_reg;
        fbz_next  = fbz_reg;
        nf_next   = nf_reg;
        dop_next  = dop_reg;
        len_next  = len_reg;
        dlv_next  = dlv_reg;
        idle_next = idle_reg;
        v         = V_NONE;
        bd        = '0;
        if (acc)
        begin
            case (in_ch.kind)
                IN_START:
                begin
                    sess_next = SP_META;
                    fph_next  = FP_HEAD;
                    bc_next   = '0;
                    lb_next   = 1'b0;
                    seq_next  = '0;
                    crc_next  = '0;
                    crch_next = '0;
                    fbz_next  = 1'b0;
                    nf_next   = 1'b0;
                    dop_next  = 1'b0;
                    len_next  = '0;
                    dlv_next  = '0;
                    idle_next = '0;
                end
                IN_TICK:
                begin
                    if (active)
                    begin
                        bd.cnt = 2'd1;
                        if (idle_reg > limit_reg)
                        begin
                            bd.r0     = end_res(ST_TIMEOUT);
                            sess_next = SP_IDLE;
                        end
                        else
                        begin
                            bd.r0 = tx_res(SYM_C);
                        end
                        if (idle_reg != 16'hFFFF)
                        begin
                            idle_next = idle_reg + 16'd1;
                        end
                    end
                end
                IN_BYTE:
                begin
                    if (active)
                    begin
                        idle_next = '0;
                        unique case (fph_reg)
                            FP_HEAD:
                            begin
                                bc_next = bc_inc;
                                if (bc_inc == 11'd1)
                                begin
                                    if (b == SYM_SOH) lb_next = 1'b0;
                                    else if (b == SYM_STX) lb_next = 1'b1;
                                    else if (b == SYM_EOT) v = V_EOT;
                                    else if (b == SYM_CAN) v = V_CAN;
                                    else v = V_BAD;
                                end
                                else if (bc_inc == 11'd2)
                                begin
                                    seq_next = b;
                                end
                                else if (seq_reg != ~b)
                                begin
                                    v = V_BAD;
                                end
                                else
                                begin
                                    fph_next = FP_DATA;
                                    bc_next  = '0;
                                    crc_next = '0;
                                    fbz_next = 1'b0;
                                    nf_next  = 1'b0;
                                    dop_next = 1'b0;
                                    if (sess_reg == SP_META) len_next = '0;
                                end
                            end
                            FP_DATA:
                            begin
                                bd.cnt   = 2'd1;
                                bd.r0    = mk_res(OK_PAYLOAD, b, bc_reg[9:0], 11'd0, 32'd0,
                                                  ST_DONE);
                                crc_next = crc_byte(crc_reg, b);
                                if (sess_reg == SP_META)
                                begin
                                    if (bc_reg == 11'd0) fbz_next = (b == 8'd0);
                                    if (!nf_reg)
                                    begin
                                        if (b == 8'd0)
                                        begin
                                            nf_next  = 1'b1;
                                            dop_next = 1'b1;
                                        end
                                    end
                                    else if (dop_reg)
                                    begin
                                        if (b >= 8'h30 && b <= 8'h39)
                                        begin
                                            len_next = (len_t[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                                             : len_t[31:0];
                                        end
                                        else
                                        begin
                                            dop_next = 1'b0;
                                        end
                                    end
                                end
                                bc_next = bc_inc;
                                if (bc_inc >= size)
                                begin
                                    fph_next = FP_TAIL;
                                    bc_next  = '0;
                                end
                            end
                            FP_TAIL:
                            begin
                                bc_next = bc_inc;
                                if (bc_inc == 11'd1) crch_next = b;
                                else v = ({crch_reg, b} == crc_reg) ? V_GOOD : V_CRC;
                            end
                            default:
                            begin
                                fph_next = FP_HEAD;
                                bc_next  = '0;
                            end
                        endcase
                        if (v != V_NONE)
                        begin
                            fph_next = FP_HEAD;
                            bc_next  = '0;
                            if (v == V_BAD)
                            begin
                                bd.cnt    = 2'd1;
                                bd.r0     = end_res(ST_ERROR);
                                sess_next = SP_IDLE;
                            end
                            else if (sess_reg == SP_META)
                            begin
                                unique case (v)
                                    V_GOOD:
                                    begin
                                        bd.cnt = 2'd3;
                                        if (fbz_reg)
                                        begin
                                            bd.r0 = mk_res(OK_ACCEPT, 8'd0, 10'd0, 11'd0,
                                                           32'd0, ST_DONE);
                                            bd.r1 = tx_res(SYM_ACK);
                                            bd.r2 = end_res(ST_DONE);
                                            sess_next = SP_IDLE;
                                        end
                                        else
                                        begin
                                            bd.r0 = tx_res(SYM_ACK);
                                            bd.r1 = mk_res(OK_FILE, 8'd0, 10'd0, 11'd0,
                                                           len_reg, ST_DONE);
                                            bd.r2 = tx_res(SYM_C);
                                            dlv_next  = '0;
                                            sess_next = SP_DATA;
                                        end
                                    end
                                    V_EOT:
                                    begin
                                        bd.cnt = 2'd2;
                                        bd.r0  = tx_res(SYM_ACK);
                                        bd.r1  = tx_res(SYM_C);
                                    end
                                    V_CAN:
                                    begin
                                        bd.cnt    = 2'd2;
                                        bd.r0     = tx_res(SYM_NAK);
                                        bd.r1     = end_res(ST_CANCEL);
                                        sess_next = SP_IDLE;
                                    end
                                    default:
                                    begin
                                        bd.cnt = 2'd3;
                                        bd.r0  = mk_res(OK_DROP, 8'd0, 10'd0, 11'd0, 32'd0,
                                                        ST_DONE);
                                        bd.r1  = tx_res(SYM_NAK);
                                        bd.r2  = end_res(ST_ERROR);
                                        sess_next = SP_IDLE;
                                    end
                                endcase
                            end
                            else
                            begin
                                unique case (v)
                                    V_GOOD:
                                    begin
                                        bd.cnt = 2'd2;
                                        if (seq_reg != 8'd0)
                                        begin
                                            bd.r0    = mk_res(OK_ACCEPT, 8'd0, 10'd0, cnt,
                                                              32'd0, ST_DONE);
                                            dlv_next = dlv_reg + {21'd0, cnt};
                                        end
                                        else
                                        begin
                                            bd.r0 = mk_res(OK_ACCEPT, 8'd0, 10'd0, 11'd0,
                                                           32'd0, ST_DONE);
                                        end
                                        bd.r1 = tx_res(SYM_ACK);
                                    end
                                    V_EOT:
                                    begin
                                        bd.cnt    = 2'd1;
                                        bd.r0     = tx_res(SYM_NAK);
                                        sess_next = SP_META;
                                    end
                                    V_CAN:
                                    begin
                                        bd.cnt    = 2'd2;
                                        bd.r0     = tx_res(SYM_ACK);
                                        bd.r1     = end_res(ST_CANCEL);
                                        sess_next = SP_IDLE;
                                    end
                                    default:
                                    begin
                                        bd.cnt = 2'd2;
                                        bd.r0  = mk_res(OK_DROP, 8'd0, 10'd0, 11'd0, 32'd0,
                                                        ST_DONE);
                                        bd.r1  = tx_res(SYM_NAK);
                                    end
                                endcase
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign push      = acc && (bd.cnt != 2'd0);
    assign push_data = bd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sess_reg  <= SP_IDLE;
            fph_reg   <= FP_HEAD;
            bc_reg    <= '0;
            lb_reg    <= 1'b0;
            seq_reg   <= '0;
            crc_reg   <= '0;
            crch_reg  <= '0;
            fbz_reg   <= 1'b0;
            nf_reg    <= 1'b0;
            dop_reg   <= 1'b0;
            len_reg   <= '0;
            dlv_reg   <= '0;
            idle_reg  <= '0;
            limit_reg <= RETRY_DEFAULT;
        end
        else
        begin
            sess_reg  <= sess_next;
            fph_reg   <= fph_next;
            bc_reg    <= bc_next;
            lb_reg    <= lb_next;
            seq_reg   <= seq_next;
            crc_reg   <= crc_next;
            crch_reg  <= crch_next;
            fbz_reg   <= fbz_next;
            nf_reg    <= nf_next;
            dop_reg   <= dop_next;
            len_reg   <= len_next;
            dlv_reg   <= dlv_next;
            idle_reg  <= idle_next;
            if (cfg_ch.valid)
            begin
                limit_reg <= cfg_ch.retry_limit;
            end
        end
    end

endmodule

// ===== sv/ymr_queue.sv =====
module ymr_queue
    import ymr_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output logic    full,
    output logic    empty,
    output bundle_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t       mem [DEPTH];
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = mem[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wp_next = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + PW'(1);
        end
        if (do_pop)
        begin
            rp_next = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + PW'(1);
        end
        if (do_push && !do_pop) cnt_next = cnt_reg + CW'(1);
        else if (do_pop && !do_push) cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== sv/ymr_back.sv =====
module ymr_back
    import ymr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      empty,
    input  bundle_t   head,
    output logic      pop,
    ymr_out_if.source out_ch
);

    logic [1:0] sel_reg, sel_next;
    logic       fire;
    logic       is_last;
    res_t       cur;

    always_comb
    begin
        case (sel_reg)
            2'd0:    cur = head.r0;
            2'd1:    cur = head.r1;
            default: cur = head.r2;
        endcase
    end

    assign is_last = (sel_reg == head.cnt - 2'd1);
    assign fire    = out_ch.valid && out_ch.ready;
    assign pop     = fire && is_last;
    assign sel_next = fire ? (is_last ? 2'd0 : sel_reg + 2'd1) : sel_reg;

    assign out_ch.valid         = !empty;
    assign out_ch.out_kind      = cur.out_kind;
    assign out_ch.out_byte      = cur.out_byte;
    assign out_ch.payload_index = cur.payload_index;
    assign out_ch.deliver_count = cur.deliver_count;
    assign out_ch.file_length   = cur.file_length;
    assign out_ch.end_status    = cur.end_status;
    assign out_ch.last          = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 2'd0;
        end
        else
        begin
            sel_reg <= sel_next;
        end
    end

endmodule

// ===== sv/ymodem_receiver_core.sv =====
// a transaction's results are registered in the result queue before they are offered
// throughput: one input transaction per cycle while the result queue has room;
//   the output side drains one result per cycle while out_ch.ready is high
// reset: rst_n is asynchronous, active low; session idle, queue empty, retry_limit 10
module ymodem_receiver_core
    import ymr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    ymr_in_if.sink    in_ch,
    ymr_cfg_if.sink   cfg_ch,
    ymr_out_if.source out_ch
);

    // front: parses bytes, keeps all session/frame state, builds result bundles
    // queue: bundles waiting for the output side
    // back: walks each bundle out one result per transaction

    logic    q_full;
    logic    q_empty;
    logic    push;
    logic    pop;
    bundle_t push_data;
    bundle_t head;

    ymr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg_ch    (cfg_ch),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    ymr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (head)
    );

    ymr_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (q_empty),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

// ===== sv/ymr_checker.sv =====
module ymr_checker
    import ymr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  out_kind,
    input logic [7:0]  out_byte,
    input logic [9:0]  payload_index,
    input logic [10:0] deliver_count,
    input logic [31:0] file_length,
    input logic [1:0]  end_status
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result offered during reset");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == OK_PAYLOAD |->
            deliver_count == 11'd0 && file_length == 32'd0 && end_status == 2'd0)
        else $error("payload result carries stray fields");

    a_index_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind != OK_PAYLOAD |-> payload_index == 10'd0)
        else $error("index on non-payload result");

    a_reply_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == OK_TX |->
            out_byte == SYM_ACK || out_byte == SYM_NAK || out_byte == SYM_C)
        else $error("bad reply byte");

endmodule

bind ymodem_receiver_core ymr_checker u_ymr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_kind      (out_ch.out_kind),
    .out_byte      (out_ch.out_byte),
    .payload_index (out_ch.payload_index),
    .deliver_count (out_ch.deliver_count),
    .file_length   (out_ch.file_length),
    .end_status    (out_ch.end_status)
);

// ===== tb/sv/ymr_session_checker.sv =====
module ymr_session_checker
    import ymr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ymr_in_if    in_ch,
    ymr_cfg_if   cfg_ch,
    ymr_out_if   out_ch,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {SESS_IDLE, SESS_META, SESS_DATA} sess_t;
    typedef enum logic [1:0] {FR_HEAD, FR_DATA, FR_TAIL} frame_t;
    typedef enum logic [2:0] {VD_NONE, VD_GOOD, VD_EOT, VD_CAN, VD_CRC, VD_BAD} verdict_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [9:0]  idx;
        logic [10:0] cnt;
        logic [31:0] flen;
        logic [1:0]  status;
        logic        last;
    } reply_t;

    reply_t      reply_q[$];
    reply_t      step_q[$];

    logic [15:0] retry_lim;
    sess_t       sess;
    frame_t      fr;
    logic [10:0] nbytes;
    logic        is_long;
    logic [7:0]  seq_no;
    logic [15:0] crc_acc;
    logic [7:0]  crc_hi;
    logic        zero_first;
    logic        name_done;
    logic        in_digits;
    logic [31:0] file_len;
    logic [31:0] delivered;
    logic [15:0] idle_cnt;

    function automatic logic [15:0] crc16_next(logic [15:0] c, logic [7:0] b);
        logic [15:0] v;
        v = c ^ {b, 8'h00};
        repeat (8)
        begin
            if (v[15])
                v = {v[14:0], 1'b0} ^ 16'h1021;
            else
                v = {v[14:0], 1'b0};
        end
        return v;
    endfunction

    task push_reply(out_kind_t k, logic [7:0] d, logic [9:0] i, logic [10:0] n,
                    logic [31:0] fl, end_status_t st);
        reply_t r;
        r = '{kind: k, data: d, idx: i, cnt: n, flen: fl, status: st, last: 1'b0};
        if (step_q.size() < 3)
            step_q.push_back(r);
    endtask

    task close_session(end_status_t st);
        push_reply(OK_END, 8'd0, 10'd0, 11'd0, 32'd0, st);
        sess = SESS_IDLE;
    endtask

    task clear_all();
        fr = FR_HEAD; nbytes = '0; is_long = 0; seq_no = '0; crc_acc = '0; crc_hi = '0;
        zero_first = 0; name_done = 0; in_digits = 0; file_len = '0; delivered = '0;
        idle_cnt = '0;
    endtask

    task judge_frame(verdict_t v);
        logic [31:0] fsize;
        logic [31:0] left;
        logic [31:0] keep;
        fsize = is_long ? LONG_SIZE : SHORT_SIZE;
        if (v == VD_BAD)
            close_session(ST_ERROR);
        else if (sess == SESS_META)
        begin
            if (v == VD_GOOD && zero_first)
            begin
                push_reply(OK_ACCEPT, 8'd0, 10'd0, 11'd0, 32'd0, ST_DONE);
                push_reply(OK_TX, SYM_ACK, 10'd0, 11'd0, 32'd0, ST_DONE);
                close_session(ST_DONE);
            end
            else if (v == VD_GOOD)
            begin
                push_reply(OK_TX, SYM_ACK, 10'd0, 11'd0, 32'd0, ST_DONE);
                push_reply(OK_FILE, 8'd0, 10'd0, 11'd0, file_len, ST_DONE);
                push_reply(OK_TX, SYM_C, 10'd0, 11'd0, 32'd0, ST_DONE);
                delivered = '0;
                sess = SESS_DATA;
            end
            else if (v == VD_EOT)
            begin
                push_reply(OK_TX, SYM_ACK, 10'd0, 11'd0, 32'd0, ST_DONE);
                push_reply(OK_TX, SYM_C, 10'd0, 11'd0, 32'd0, ST_DONE);
            end
            else if (v == VD_CAN)
            begin
                push_reply(OK_TX, SYM_NAK, 10'd0, 11'd0, 32'd0, ST_DONE);
                close_session(ST_CANCEL);
            end
            else
            begin
                push_reply(OK_DROP, 8'd0, 10'd0, 11'd0, 32'd0, ST_DONE);
                push_reply(OK_TX, SYM_NAK, 10'd0, 11'd0, 32'd0, ST_DONE);
                close_session(ST_ERROR);
            end
        end
        else
        begin
            if (v == VD_GOOD)
            begin
                keep = '0;
                if (seq_no != 8'd0)
                begin
                    left = (file_len > delivered) ? file_len - delivered : 32'd0;
                    keep = (left < fsize) ? left : fsize;
                    delivered = delivered + keep;
                end
                push_reply(OK_ACCEPT, 8'd0, 10'd0, keep[10:0], 32'd0, ST_DONE);
                push_reply(OK_TX, SYM_ACK, 10'd0, 11'd0, 32'd0, ST_DONE);
            end
            else if (v == VD_EOT)
            begin
                push_reply(OK_TX, SYM_NAK, 10'd0, 11'd0, 32'd0, ST_DONE);
                sess = SESS_META;
            end
            else if (v == VD_CAN)
            begin
                push_reply(OK_TX, SYM_ACK, 10'd0, 11'd0, 32'd0, ST_DONE);
                close_session(ST_CANCEL);
            end
            else
            begin
                push_reply(OK_DROP, 8'd0, 10'd0, 11'd0, 32'd0, ST_DONE);
                push_reply(OK_TX, SYM_NAK, 10'd0, 11'd0, 32'd0, ST_DONE);
            end
        end
    endtask

    task take_byte(logic [7:0] b);
        verdict_t    v;
        logic [63:0] acc;
        logic [10:0] fsize;
        v = VD_NONE;
        fsize = is_long ? 11'(LONG_SIZE) : 11'(SHORT_SIZE);
        idle_cnt = '0;
        if (fr == FR_HEAD)
        begin
            nbytes = nbytes + 1;
            if (nbytes == 1)
            begin
                if (b == SYM_SOH)
                    is_long = 0;
                else if (b == SYM_STX)
                    is_long = 1;
                else if (b == SYM_EOT)
                    v = VD_EOT;
                else if (b == SYM_CAN)
                    v = VD_CAN;
                else
                    v = VD_BAD;
            end
            else if (nbytes == 2)
                seq_no = b;
            else if (seq_no != ~b)
                v = VD_BAD;
            else
            begin
                fr = FR_DATA; nbytes = '0; crc_acc = '0;
                zero_first = 0; name_done = 0; in_digits = 0;
                if (sess == SESS_META)
                    file_len = '0;
            end
        end
        else if (fr == FR_DATA)
        begin
            push_reply(OK_PAYLOAD, b, nbytes[9:0], 11'd0, 32'd0, ST_DONE);
            crc_acc = crc16_next(crc_acc, b);
            if (sess == SESS_META)
            begin
                if (nbytes == 0)
                    zero_first = (b == 8'd0);
                if (!name_done)
                begin
                    if (b == 8'd0)
                    begin
                        name_done = 1;
                        in_digits = 1;
                    end
                end
                else if (in_digits)
                begin
                    if (b >= "0" && b <= "9")
                    begin
                        acc = 64'(file_len) * 64'd10 + 64'(b - "0");
                        file_len = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
                    end
                    else
                        in_digits = 0;
                end
            end
            nbytes = nbytes + 1;
            if (nbytes >= fsize)
            begin
                fr = FR_TAIL;
                nbytes = '0;
            end
        end
        else
        begin
            nbytes = nbytes + 1;
            if (nbytes == 1)
                crc_hi = b;
            else
                v = ({crc_hi, b} == crc_acc) ? VD_GOOD : VD_CRC;
        end
        if (v != VD_NONE)
        begin
            judge_frame(v);
            fr = FR_HEAD;
            nbytes = '0;
        end
    endtask

    // works out the results of one input transaction and queues them
    task predict_item(logic [1:0] k, logic [7:0] b);
        reply_t r;
        logic   live;
        live = (sess == SESS_META) || (sess == SESS_DATA);
        step_q.delete();
        if (k == IN_START)
        begin
            clear_all();
            sess = SESS_META;
        end
        else if (k == IN_TICK && live)
        begin
            if (idle_cnt > retry_lim)
                close_session(ST_TIMEOUT);
            else
                push_reply(OK_TX, SYM_C, 10'd0, 11'd0, 32'd0, ST_DONE);
            if (idle_cnt != 16'hFFFF)
                idle_cnt = idle_cnt + 1;
        end
        else if (k == IN_BYTE && live)
            take_byte(b);
        if (step_q.size() > 0)
        begin
            r = step_q.pop_back();
            r.last = 1;
            step_q.push_back(r);
        end
        foreach (step_q[i])
            reply_q.push_back(step_q[i]);
    endtask

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: result mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        fail_count = fail_count + 1;
    endtask

    task check_result();
        reply_t w;
        if (reply_q.size() == 0)
        begin
            report_mismatch("unexpected result kind", 32'(out_ch.out_kind), 32'hFFFF_FFFF);
            return;
        end
        w = reply_q.pop_front();
        if (out_ch.out_kind !== w.kind)
            report_mismatch("out_kind", 32'(out_ch.out_kind), 32'(w.kind));
        if (out_ch.out_byte !== w.data)
            report_mismatch("out_byte", 32'(out_ch.out_byte), 32'(w.data));
        if (out_ch.payload_index !== w.idx)
            report_mismatch("payload_index", 32'(out_ch.payload_index), 32'(w.idx));
        if (out_ch.deliver_count !== w.cnt)
            report_mismatch("deliver_count", 32'(out_ch.deliver_count), 32'(w.cnt));
        if (out_ch.file_length !== w.flen)
            report_mismatch("file_length", out_ch.file_length, w.flen);
        if (out_ch.end_status !== w.status)
            report_mismatch("end_status", 32'(out_ch.end_status), 32'(w.status));
        if (out_ch.last !== w.last)
            report_mismatch("last", 32'(out_ch.last), 32'(w.last));
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_lim = RETRY_DEFAULT;
            sess = SESS_IDLE;
            clear_all();
            reply_q.delete();
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                retry_lim = cfg_ch.retry_limit;
            if (in_ch.valid && in_ch.ready)
                predict_item(in_ch.kind, in_ch.rx_byte);
            if (out_ch.valid && out_ch.ready)
                check_result();
        end
        pending = reply_q.size();
    end

endmodule

// ===== tb/sv/tb_ymodem_receiver_core.sv =====
module tb_ymodem_receiver_core;
    import ymr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;

    ymr_in_if  in_if ();
    ymr_out_if out_if ();
    ymr_cfg_if cfg_if ();

    int fail_count;
    int pending;

    // stimulus bookkeeping
    int          items_sent;
    int          item_goal;
    bit          cut_frames;
    int          tx_idle_pct;
    int          rx_idle_pct;
    logic [7:0]  frame_buf [1024];

    ymodem_receiver_core u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .cfg_ch (cfg_if),
        .out_ch (out_if)
    );

    ymr_session_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_if),
        .cfg_ch     (cfg_if),
        .out_ch     (out_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // result side stalls at random, changing at the falling edge
    always @(negedge clk)
    begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // crc-16/xmodem for building frames
    function automatic logic [15:0] frame_crc(int n);
        logic [15:0] c;
        c = '0;
        for (int i = 0; i < n; i++)
        begin
            c = c ^ {frame_buf[i], 8'h00};
            repeat (8)
            begin
                c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // one input transaction, with random sender gaps in front of it
    task send(in_kind_t k, logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_if.valid = 0;
            @(negedge clk);
        end
        in_if.valid   = 1;
        in_if.kind    = k;
        in_if.rx_byte = b;
        do
            @(posedge clk);
        while (!in_if.ready);
        items_sent++;
    endtask

    // drop valid and wait until every expected result has been seen
    task drain();
        @(negedge clk);
        in_if.valid = 0;
        while (pending != 0)
            @(negedge clk);
        // an item with no result may still be in flight
        repeat (4) @(negedge clk);
    endtask

    task set_retry_limit(logic [15:0] lim);
        drain();
        cfg_if.valid       = 1;
        cfg_if.retry_limit = lim;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid = 0;
    endtask

    // header, complement, payload from frame_buf and crc; a broken complement
    // ends the session, so the rest of the frame is not sent
    task send_frame(bit long_blk, logic [7:0] seq_no, bit bad_comp, bit bad_crc);
        int          n;
        logic [15:0] c;
        n = long_blk ? LONG_SIZE : SHORT_SIZE;
        send(IN_BYTE, long_blk ? SYM_STX : SYM_SOH);
        send(IN_BYTE, seq_no);
        send(IN_BYTE, bad_comp ? (~seq_no ^ (8'h01 << $urandom_range(7))) : ~seq_no);
        if (bad_comp)
            return;
        for (int i = 0; i < n; i++)
        begin
            // frame left unfinished once the stimulus budget is spent
            if (cut_frames && items_sent >= item_goal)
                return;
            // a retry tick in the middle of a frame is honoured too
            if ($urandom_range(199) == 0)
                send(IN_TICK, 8'd0);
            send(IN_BYTE, frame_buf[i]);
        end
        c = frame_crc(n);
        if (bad_crc)
            c = c ^ (16'h0001 << $urandom_range(15));
        send(IN_BYTE, c[15:8]);
        send(IN_BYTE, c[7:0]);
    endtask

    task fill_random(int n);
        for (int i = 0; i < n; i++)
            frame_buf[i] = 8'($urandom_range(255));
    endtask

    // metadata block: name, zero, decimal length, a terminator, then filler
    task fill_metadata();
        int    pos;
        int    sel;
        string digits;
        fill_random(SHORT_SIZE);
        pos = 0;
        repeat ($urandom_range(1, 12))
        begin
            frame_buf[pos] = 8'($urandom_range(1, 255));
            pos++;
        end
        frame_buf[pos] = 8'd0;
        pos++;
        sel = $urandom_range(5);
        case (sel)
            0: digits = "";
            1: digits = "99999999999";     // saturates
            2: digits = "4294967295";
            3: digits = $sformatf("%0d", $urandom_range(0, 300));
            default: digits = $sformatf("%0d", $urandom_range(0, 4000));
        endcase
        for (int i = 0; i < digits.len(); i++)
        begin
            frame_buf[pos] = digits[i];
            pos++;
        end
        case ($urandom_range(2))
            0: frame_buf[pos] = 8'd0;
            1: frame_buf[pos] = 8'h20;
            default: frame_buf[pos] = "x";
        endcase
    endtask

    // one session with random content, mostly well formed
    task run_session();
        int          nframes;
        logic [7:0]  seq_no;
        bit          bad_comp;
        bit          bad_crc;
        send(IN_START, 8'd0);
        if ($urandom_range(9) == 0)
        begin
            // noise: stray bytes, ticks and ignored transactions
            repeat ($urandom_range(1, 8))
            begin
                case ($urandom_range(3))
                    0: send(IN_BYTE, 8'($urandom_range(255)));
                    1: send(IN_NONE, 8'($urandom_range(255)));
                    default: send(IN_TICK, 8'd0);
                endcase
            end
            return;
        end
        if ($urandom_range(9) == 0)
        begin
            send(IN_BYTE, SYM_EOT);
            send(IN_TICK, 8'd0);
        end
        fill_metadata();
        if ($urandom_range(7) == 0)
            frame_buf[0] = 8'd0;
        bad_crc = ($urandom_range(9) == 0);
        send_frame(0, 8'd0, 0, bad_crc);
        if (bad_crc || frame_buf[0] == 8'd0 || items_sent >= item_goal)
            return;
        nframes = $urandom_range(1, 3);
        seq_no = ($urandom_range(5) == 0) ? 8'd0 : 8'd1;
        for (int f = 0; f < nframes && items_sent < item_goal; f++)
        begin
            if ($urandom_range(4) == 0)
                send(IN_TICK, 8'd0);
            if ($urandom_range(9) == 0)
                send(IN_NONE, 8'($urandom_range(255)));
            fill_random(SHORT_SIZE);
            bad_comp = ($urandom_range(19) == 0);
            bad_crc  = ($urandom_range(7) == 0);
            send_frame(0, seq_no, bad_comp, bad_crc);
            if (bad_comp)
                return;
            seq_no = seq_no + 1;
        end
        if (cut_frames && items_sent >= item_goal)
            return;
        if ($urandom_range(3) == 0)
        begin
            send(IN_BYTE, SYM_CAN);
            return;
        end
        send(IN_BYTE, SYM_EOT);
        send(IN_BYTE, SYM_EOT);
        if ($urandom_range(1) == 0 && items_sent < item_goal)
        begin
            fill_random(SHORT_SIZE);
            frame_buf[0] = 8'd0;
            send_frame(0, 8'd0, 0, 0);
        end
        else
            send(IN_BYTE, SYM_CAN);
    endtask

    task run_random(int goal, bit cut);
        item_goal  = goal;
        cut_frames = cut;
        while (items_sent < goal)
            run_session();
    endtask

    initial
    begin
        rst_n = 0;
        in_if.valid = 0;
        in_if.kind = IN_NONE;
        in_if.rx_byte = '0;
        cfg_if.valid = 0;
        cfg_if.retry_limit = '0;
        out_if.ready = 0;
        items_sent = 0;
        item_goal = 0;
        cut_frames = 0;
        tx_idle_pct = 36;
        rx_idle_pct = 47;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed part, retry limit at its low end
        set_retry_limit(16'd0);
        send(IN_BYTE, 8'h55);          // no session yet: ignored
        send(IN_TICK, 8'd0);
        send(IN_NONE, 8'hAA);
        send(IN_START, 8'd0);
        send(IN_TICK, 8'd0);           // C
        send(IN_TICK, 8'd0);           // timeout
        send(IN_START, 8'd0);
        send(IN_BYTE, SYM_CAN);        // cancel in metadata phase
        send(IN_START, 8'd0);
        send(IN_BYTE, SYM_EOT);        // ACK then C
        send(IN_BYTE, 8'hFF);          // bad header byte
        send(IN_START, 8'd0);
        send(IN_BYTE, SYM_SOH);
        send(IN_BYTE, 8'h05);
        send(IN_BYTE, 8'hFB);          // wrong complement
        send(IN_START, 8'd0);
        send(IN_BYTE, SYM_STX);
        send(IN_BYTE, 8'h00);
        send(IN_BYTE, 8'h00);          // wrong complement on a long header
        send(IN_START, 8'd0);
        send(IN_START, 8'd0);          // restart while running

        // whole sessions through the data phase
        run_random(200, 0);

        // swap who stalls, retry limit at its high end
        tx_idle_pct = 47;
        rx_idle_pct = 36;
        set_retry_limit(16'hFFFF);
        run_random(360, 1);

        // full rate, small retry limit
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_retry_limit(16'd3);
        run_random(430, 1);

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_ymodem_receiver_core passed");
        else
            $display("tb_ymodem_receiver_core failed");
        $finish;
    end

    // hang guard
    initial
    begin
        #5ms;
        $display("tb_ymodem_receiver_core failed");
        $finish;
    end

endmodule
